// ===== rtl/core/sacl_pkg.sv =====
// ----------------------------------------------------------------------------
// sacl_pkg: shared types and constants of the LRU cache simulator
// Command codes, register indexes, field widths and controller commands.
// ----------------------------------------------------------------------------
package sacl_pkg;

  localparam int ADDR_W  = 64;
  localparam int TAG_W   = 63;
  localparam int CNT_W   = 32;
  localparam int WAYID_W = 3;
  localparam int CFG_W   = 5;
  localparam int CIDX_W  = 2;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_STORE  = 2'd1,
    CMD_MODIFY = 2'd2,
    CMD_IFETCH = 2'd3
  } cmd_t;

  typedef enum logic [CIDX_W-1:0] {
    REG_SET_BITS    = 2'd0,
    REG_OFFSET_BITS = 2'd1,
    REG_WAYS_IN_USE = 2'd2,
    REG_UNUSED      = 2'd3
  } reg_idx_t;

  // controller to datapath
  typedef struct packed {
    logic capture;  // latch the incoming address
    logic read;     // read the set row
    logic compute;  // perform one access and load the result register
    logic first;    // take the row from memory, not from the row register
    logic last;     // final result of this input
  } ctrl_cmd_t;

endpackage

// ===== rtl/core/set_assoc_cache_lru_sim_top.sv =====
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_sim_top: tag-only set-associative cache with LRU
// Counts hits, misses and evictions for a stream of memory accesses.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one access per transfer, a command
//   and a 64-bit byte address. Load and store give one result, modify gives
//   two (the second always a hit), instruction fetch gives none.
//   Output channel (out_valid / out_stall): one result per access with the
//   hit, eviction and way flags and the running saturating totals.
//   Configuration: cfg_we, cfg_index, cfg_data; write only while idle.
// Sequence:
//   An access steps through accept, set row read from the row memory,
//   then compare, victim choice and write back. A modify adds a second
//   access on the row register; an instruction fetch is only accepted.
//   The row memory is read, then written back, one access in flight at a time.
//   The next input is accepted while the last result still waits.
// Reset:
//   Synchronous rst clears totals, per-set written flags and configuration
//   (set_bits 4, offset_bits 4, ways_in_use 1). No clearing pass is needed.
// Stall:
//   While out_stall holds a waiting result, a pending access step holds
//   and in_stall stays high until the result is transferred.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_sim_top #(
  parameter int MAX_SET_BITS = 8,
  parameter int MAX_WAYS     = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [sacl_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [sacl_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    command,
  input  logic [sacl_pkg::ADDR_W-1:0]   access_address,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          was_hit,
  output logic                          was_eviction,
  output logic [sacl_pkg::WAYID_W-1:0]  way_used,
  output logic                          last_of_run,
  output logic [sacl_pkg::CNT_W-1:0]    hit_total,
  output logic [sacl_pkg::CNT_W-1:0]    miss_total,
  output logic [sacl_pkg::CNT_W-1:0]    eviction_total
);

  sacl_pkg::ctrl_cmd_t ctl;

  // sequencer
  sacl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl)
  );

  // datapath
  sacl_dp #(.MAX_SET_BITS(MAX_SET_BITS), .MAX_WAYS(MAX_WAYS)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .ctl            (ctl),
    .access_address (access_address),
    .was_hit        (was_hit),
    .was_eviction   (was_eviction),
    .way_used       (way_used),
    .last_of_run    (last_of_run),
    .hit_total      (hit_total),
    .miss_total     (miss_total),
    .eviction_total (eviction_total)
  );

endmodule

// ===== rtl/core/sacl_ram.sv =====
// ----------------------------------------------------------------------------
// sacl_ram: generic single-port-write, registered-read RAM
// One write and one read address per cycle; read data is registered.
// ----------------------------------------------------------------------------
module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/sacl_ctrl.sv =====
// ----------------------------------------------------------------------------
// sacl_ctrl: access sequencer
// Accepts inputs, steps read / access / second access, owns the output valid.
// ----------------------------------------------------------------------------
module sacl_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          command,
  output logic                out_valid,
  input  logic                out_stall,
  output sacl_pkg::ctrl_cmd_t ctl
);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_ACC1, S_ACC2} state_t;

  state_t          state;
  sacl_pkg::cmd_t  cmd_reg;
  logic            accept;
  logic            can_issue;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && (state == S_IDLE);
  assign can_issue = !out_valid || !out_stall;

  // decode commands to the datapath
  always_comb begin
    ctl         = '0;
    ctl.capture = accept;
    ctl.read    = (state == S_READ);
    case (state)
      S_ACC1: begin
        ctl.compute = can_issue;
        ctl.first   = 1'b1;
        ctl.last    = (cmd_reg != sacl_pkg::CMD_MODIFY);
      end
      S_ACC2: begin
        ctl.compute = can_issue;
        ctl.last    = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // hold state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cmd_reg   <= sacl_pkg::CMD_LOAD;
      out_valid <= 1'b0;
    end else begin
      if (ctl.compute) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && (sacl_pkg::cmd_t'(command) != sacl_pkg::CMD_IFETCH)) begin
            cmd_reg <= sacl_pkg::cmd_t'(command);
            state   <= S_READ;
          end
        end
        S_READ: begin
          state <= S_ACC1;
        end
        S_ACC1: begin
          if (can_issue) begin
            state <= (cmd_reg == sacl_pkg::CMD_MODIFY) ? S_ACC2 : S_IDLE;
          end
        end
        S_ACC2: begin
          if (can_issue) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a second access only follows a first access of a modify
  a_acc2_entry: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACC2 && $past(state) != S_ACC2) |-> $past(state) == S_ACC1)
    else $error("second access entered out of sequence");

  // never overwrite a result the receiver has not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl.compute |-> !(out_valid && out_stall))
    else $error("result register overwritten while stalled");

  // an instruction fetch leaves the sequencer idle
  a_ifetch_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && command == sacl_pkg::CMD_IFETCH) |=> state == S_IDLE)
    else $error("instruction fetch started an access");

  // a compute only happens in an access state
  a_compute_state: assert property (@(posedge clk) disable iff (rst)
    ctl.compute |-> (state == S_ACC1 || state == S_ACC2))
    else $error("compute outside an access state");

endmodule

// ===== rtl/core/sacl_dp.sv =====
// ----------------------------------------------------------------------------
// sacl_dp: cache tag datapath
// Configuration, set row memory, tag compare, victim choice, ranks, totals.
// ----------------------------------------------------------------------------
module sacl_dp #(
  parameter int MAX_SET_BITS = 8,
  parameter int MAX_WAYS     = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [sacl_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [sacl_pkg::CFG_W-1:0]    cfg_data,
  input  sacl_pkg::ctrl_cmd_t           ctl,
  input  logic [sacl_pkg::ADDR_W-1:0]   access_address,
  output logic                          was_hit,
  output logic                          was_eviction,
  output logic [sacl_pkg::WAYID_W-1:0]  way_used,
  output logic                          last_of_run,
  output logic [sacl_pkg::CNT_W-1:0]    hit_total,
  output logic [sacl_pkg::CNT_W-1:0]    miss_total,
  output logic [sacl_pkg::CNT_W-1:0]    eviction_total
);

  localparam int SETS   = 1 << MAX_SET_BITS;
  localparam int RANK_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int ROW_W  = MAX_WAYS * (1 + sacl_pkg::TAG_W + RANK_W);

  typedef logic [MAX_WAYS-1:0]                     vld_t;
  typedef logic [MAX_WAYS-1:0][sacl_pkg::TAG_W-1:0] tags_t;
  typedef logic [MAX_WAYS-1:0][RANK_W-1:0]          ranks_t;

  logic [3:0]                  set_bits;
  logic [4:0]                  offset_bits;
  logic [3:0]                  ways_in_use;
  logic [sacl_pkg::ADDR_W-1:0] addr;
  logic [SETS-1:0]             row_written;
  logic                        rd_written;
  logic [ROW_W-1:0]            rdata;
  vld_t                        row_v;
  tags_t                       row_t;
  ranks_t                      row_r;
  vld_t                        cur_v, new_v;
  tags_t                       cur_t, new_t;
  ranks_t                      cur_r, new_r;
  logic [MAX_SET_BITS-1:0]     set_idx;
  logic [sacl_pkg::TAG_W-1:0]  tag;
  logic                        hit, found, evict;
  logic [RANK_W-1:0]           way;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits    <= 4'd4;
      offset_bits <= 5'd4;
      ways_in_use <= 4'd1;
    end else if (cfg_we) begin
      case (sacl_pkg::reg_idx_t'(cfg_index))
        sacl_pkg::REG_SET_BITS:    set_bits    <= cfg_data[3:0];
        sacl_pkg::REG_OFFSET_BITS: offset_bits <= cfg_data;
        sacl_pkg::REG_WAYS_IN_USE: ways_in_use <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  // split the address by the configured bit counts
  always_comb begin
    int unsigned sb;
    logic [sacl_pkg::ADDR_W-1:0] sh;
    sb = int'(set_bits);
    if (sb < 1) sb = 1;
    if (sb > MAX_SET_BITS) sb = MAX_SET_BITS;
    sh      = addr >> (7'(sb) + 7'(offset_bits));
    tag     = sh[sacl_pkg::TAG_W-1:0];
    sh      = (addr >> offset_bits) & ((64'd1 << sb) - 64'd1);
    set_idx = sh[MAX_SET_BITS-1:0];
  end

  // set row memory
  sacl_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_row_ram (
    .clk   (clk),
    .we    (ctl.compute),
    .waddr (set_idx),
    .wdata ({new_v, new_t, new_r}),
    .re    (ctl.read),
    .raddr (set_idx),
    .rdata (rdata)
  );

  // track which rows were written since reset; capture address and row
  always_ff @(posedge clk) begin
    if (rst) begin
      row_written <= '0;
    end else if (ctl.compute) begin
      row_written[set_idx] <= 1'b1;
    end
    if (ctl.read) begin
      rd_written <= row_written[set_idx];
    end
    if (ctl.capture) begin
      addr <= access_address;
    end
    if (ctl.compute) begin
      row_v <= new_v;
      row_t <= new_t;
      row_r <= new_r;
    end
  end

  // pick the source row: memory for a first access, the row register after
  always_comb begin
    if (ctl.first) begin
      {cur_v, cur_t, cur_r} = rdata;
      if (!rd_written) begin
        cur_v = '0;
        cur_r = '0;
      end
    end else begin
      cur_v = row_v;
      cur_t = row_t;
      cur_r = row_r;
    end
  end

  // look up, choose the way and update the recency ranks
  always_comb begin
    int unsigned       ways;
    logic [RANK_W-1:0] hway, iway, vway, best, cap, rr;
    ways = int'(ways_in_use);
    if (ways < 1) ways = 1;
    if (ways > MAX_WAYS) ways = MAX_WAYS;
    cap  = RANK_W'(ways - 1);
    hit  = 1'b0;
    found = 1'b0;
    hway = '0;
    iway = '0;
    vway = '0;
    best = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (i < ways && !hit && cur_v[i] && cur_t[i] == tag) begin
        hit  = 1'b1;
        hway = RANK_W'(i);
      end
      if (i < ways && !found && !cur_v[i]) begin
        found = 1'b1;
        iway  = RANK_W'(i);
      end
    end
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (i < ways && (i == 0 || cur_r[i] > best)) begin
        best = cur_r[i];
        vway = RANK_W'(i);
      end
    end
    way   = hit ? hway : (found ? iway : vway);
    evict = !hit && !found;
    new_v = cur_v;
    new_t = cur_t;
    new_r = cur_r;
    if (!hit) begin
      new_v[way] = 1'b1;
      new_t[way] = tag;
    end
    rr = cur_r[way];
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (i < ways && RANK_W'(i) != way && cur_r[i] <= rr && cur_r[i] < cap) begin
        new_r[i] = cur_r[i] + RANK_W'(1);
      end
    end
    new_r[way] = '0;
  end

  // saturating totals and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_total      <= '0;
      miss_total     <= '0;
      eviction_total <= '0;
    end else if (ctl.compute) begin
      if (hit && hit_total != '1) hit_total <= hit_total + 1'b1;
      if (!hit && miss_total != '1) miss_total <= miss_total + 1'b1;
      if (evict && eviction_total != '1) eviction_total <= eviction_total + 1'b1;
    end
    if (ctl.compute) begin
      was_hit      <= hit;
      was_eviction <= evict;
      way_used     <= sacl_pkg::WAYID_W'(way);
      last_of_run  <= ctl.last;
    end
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the set-associative LRU cache simulator
// Drives access streams through set/offset/way settings, predicts hit, miss,
// eviction, way and running totals per access and checks every result transfer.
// ----------------------------------------------------------------------------
module tb;

  localparam int NSETS     = 256;
  localparam int NWAYS     = 8;
  localparam int WDOG_MAX  = 2000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] addr;
  } access_t;

  typedef struct packed {
    logic        hit;
    logic        evict;
    logic [2:0]  way;
    logic        last;
    logic [31:0] hits;
    logic [31:0] misses;
    logic [31:0] evicts;
  } outcome_t;

  logic clk, rst;
  logic cfg_we;
  logic [sacl_pkg::CIDX_W-1:0] cfg_index;
  logic [sacl_pkg::CFG_W-1:0] cfg_data;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [1:0] command;
  logic [63:0] access_address;
  logic was_hit, was_eviction, last_of_run;
  logic [2:0] way_used;
  logic [31:0] hit_total, miss_total, eviction_total;

  set_assoc_cache_lru_sim_top u_top (.*);

  // cache shadow state
  bit          shadow_valid [NSETS][NWAYS];
  logic [63:0] shadow_tag   [NSETS][NWAYS];
  int unsigned shadow_rank  [NSETS][NWAYS];
  logic [31:0] n_hits, n_misses, n_evicts;
  int unsigned cur_sets, cur_offset, cur_ways;

  access_t  pending_q[$];
  outcome_t outcome_q[$];
  int errors;
  bit quiet;   // no idling in the final stretch
  bit hold_in; // sender paused
  int wdog;
  int idle_left;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  task automatic report(input string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  // perform one predicted access and queue its outcome
  task automatic predict_access(input logic [63:0] addr, input bit last);
    int unsigned sb, ob, nw, s, w, i, r;
    logic [63:0] tg;
    bit hit, ev, found;
    outcome_t o;
    sb = (cur_sets < 1) ? 1 : (cur_sets > 8 ? 8 : cur_sets);
    nw = (cur_ways < 1) ? 1 : (cur_ways > 8 ? 8 : cur_ways);
    ob = cur_offset;
    tg = (sb + ob >= 64) ? 64'd0 : (addr >> (sb + ob));
    s  = (addr >> ob) & ((1 << sb) - 1);
    hit = 0; ev = 0; found = 0; w = 0;
    for (i = 0; i < nw; i++)
      if (!hit && shadow_valid[s][i] && shadow_tag[s][i] == tg) begin
        hit = 1; w = i;
      end
    if (!hit) begin
      for (i = 0; i < nw; i++)
        if (!found && !shadow_valid[s][i]) begin
          found = 1; w = i;
        end
      if (!found) begin
        w = 0;
        for (i = 1; i < nw; i++)
          if (shadow_rank[s][i] > shadow_rank[s][w]) w = i;
        ev = 1;
      end
      shadow_valid[s][w] = 1;
      shadow_tag[s][w] = tg;
    end
    r = shadow_rank[s][w];
    for (i = 0; i < nw; i++)
      if (i != w && shadow_rank[s][i] <= r && shadow_rank[s][i] < nw - 1)
        shadow_rank[s][i]++;
    shadow_rank[s][w] = 0;
    if (hit) begin
      if (n_hits != '1) n_hits++;
    end else begin
      if (n_misses != '1) n_misses++;
    end
    if (ev && n_evicts != '1) n_evicts++;
    o = '{hit, ev, w[2:0], last, n_hits, n_misses, n_evicts};
    outcome_q.push_back(o);
  endtask

  // driver: present pending transfers with random idle bursts
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
      command <= '0;
      access_address <= '0;
      idle_left = 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        if (command != sacl_pkg::CMD_IFETCH)
          predict_access(access_address, command != sacl_pkg::CMD_MODIFY);
        if (command == sacl_pkg::CMD_MODIFY) predict_access(access_address, 1);
      end
      if (pending_q.size() == 0 || hold_in) begin
        in_valid <= 0;
      end else if (!quiet && idle_left > 0) begin
        idle_left--;
        in_valid <= 0;
      end else if (!quiet && $urandom_range(3) == 0) begin
        idle_left = $urandom_range(0, 2);
        in_valid <= 0;
      end else begin
        access_t a;
        a = pending_q.pop_front();
        in_valid <= 1;
        command <= a.cmd;
        access_address <= a.addr;
      end
    end
  end

  // receiver stall in short random bursts
  int stall_left;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 0;
      stall_left = 0;
    end else if (quiet) begin
      out_stall <= 0;
    end else begin
      if (stall_left == 0 && $urandom_range(5) == 0) stall_left = $urandom_range(1, 3);
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // monitor: check each result transfer against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (outcome_q.size() == 0) report("result with nothing predicted");
      else begin
        outcome_t e;
        e = outcome_q.pop_front();
        if (was_hit !== e.hit) report($sformatf("was_hit %b exp %b", was_hit, e.hit));
        if (was_eviction !== e.evict)
          report($sformatf("was_eviction %b exp %b", was_eviction, e.evict));
        if (way_used !== e.way) report($sformatf("way_used %0d exp %0d", way_used, e.way));
        if (last_of_run !== e.last)
          report($sformatf("last_of_run %b exp %b", last_of_run, e.last));
        if (hit_total !== e.hits)
          report($sformatf("hit_total %0d exp %0d", hit_total, e.hits));
        if (miss_total !== e.misses)
          report($sformatf("miss_total %0d exp %0d", miss_total, e.misses));
        if (eviction_total !== e.evicts)
          report($sformatf("eviction_total %0d exp %0d", eviction_total, e.evicts));
      end
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_MAX) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic push(input logic [1:0] c, input logic [63:0] a);
    access_t x;
    x.cmd = c;
    x.addr = a;
    pending_q.push_back(x);
  endtask

  // wait until everything sent has been answered, plus settling time
  task automatic drain();
    while (pending_q.size() > 0 || in_valid || outcome_q.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input sacl_pkg::reg_idx_t idx, input int unsigned val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val[sacl_pkg::CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 0;
    if (idx == sacl_pkg::REG_SET_BITS) cur_sets = val & 15;
    else if (idx == sacl_pkg::REG_OFFSET_BITS) cur_offset = val & 31;
    else if (idx == sacl_pkg::REG_WAYS_IN_USE) cur_ways = val & 15;
  endtask

  // random phase: reuse a small pool of tags so hits and evictions occur
  task automatic random_phase(input int count);
    logic [63:0] pool[16];
    logic [63:0] a;
    int k;
    for (k = 0; k < 16; k++) pool[k] = {$urandom, $urandom};
    for (k = 0; k < count; k++) begin
      if ($urandom_range(9) == 0) a = {$urandom, $urandom};
      else begin
        a = pool[$urandom_range(15)];
        a = a ^ (64'($urandom_range(3)) << (cur_offset + $urandom_range(1)));
      end
      push(2'($urandom_range(3)), a);
    end
  endtask

  initial begin
    int p;
    rst = 1;
    cfg_we = 0; cfg_index = '0; cfg_data = '0;
    quiet = 0; hold_in = 0; errors = 0;
    n_hits = 0; n_misses = 0; n_evicts = 0;
    cur_sets = 4; cur_offset = 4; cur_ways = 1;
    foreach (shadow_valid[i, j]) begin
      shadow_valid[i][j] = 0;
      shadow_rank[i][j] = 0;
    end
    repeat (7) @(posedge clk);
    rst <= 0;

    // directed: reset settings, each command, address extremes
    push(sacl_pkg::CMD_LOAD, 64'd0);
    push(sacl_pkg::CMD_LOAD, 64'd0);
    push(sacl_pkg::CMD_STORE, 64'hFFFF_FFFF_FFFF_FFFF);
    push(sacl_pkg::CMD_MODIFY, 64'h1234_5678_9ABC_DEF0);
    push(sacl_pkg::CMD_IFETCH, 64'hAAAA_AAAA_AAAA_AAAA);
    push(sacl_pkg::CMD_LOAD, 64'h5555_5555_5555_5555);
    push(sacl_pkg::CMD_LOAD, 64'h100);
    push(sacl_pkg::CMD_LOAD, 64'h0);
    drain();

    // pause the sender mid-stream until every result is in, then resume
    push(sacl_pkg::CMD_MODIFY, 64'h40);
    push(sacl_pkg::CMD_LOAD, 64'h80);
    push(sacl_pkg::CMD_STORE, 64'h40);
    push(sacl_pkg::CMD_MODIFY, 64'hC0);
    repeat (4) @(posedge clk);
    hold_in = 1;
    while (in_valid || outcome_q.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
    hold_in = 0;
    drain();

    // extremes: zero and over-range counts, full and zero offset
    write_reg(sacl_pkg::REG_SET_BITS, 0);
    write_reg(sacl_pkg::REG_OFFSET_BITS, 0);
    write_reg(sacl_pkg::REG_WAYS_IN_USE, 0);
    push(sacl_pkg::CMD_LOAD, 64'd1);
    push(sacl_pkg::CMD_LOAD, 64'd3);
    push(sacl_pkg::CMD_STORE, 64'd1);
    drain();
    write_reg(sacl_pkg::REG_SET_BITS, 15);
    write_reg(sacl_pkg::REG_OFFSET_BITS, 31);
    write_reg(sacl_pkg::REG_WAYS_IN_USE, 15);
    for (int k = 0; k < 10; k++) push(sacl_pkg::CMD_LOAD, 64'(k) << 39);
    push(sacl_pkg::CMD_LOAD, 64'h0);
    push(sacl_pkg::CMD_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF);
    drain();

    // random phases across settings, the last with no idling
    for (p = 0; p < 6; p++) begin
      write_reg(sacl_pkg::REG_SET_BITS, $urandom_range(0, 9));
      write_reg(sacl_pkg::REG_OFFSET_BITS, (p == 0) ? 16 : $urandom_range(0, 16));
      write_reg(sacl_pkg::REG_WAYS_IN_USE, (p == 1) ? 8 : $urandom_range(1, 9));
      if (p == 5) quiet = 1;
      random_phase(180);
      drain();
    end

    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
